>>> design/bdg_pkg.sv
// shared types, constants and helpers for the glitch-tolerant button debouncer
package bdg_pkg;

    localparam int TIMER_W    = 10;
    localparam int LEVELS_W   = 6;
    localparam int MASK_W     = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
    localparam logic [TIMER_W-1:0] SETTLE_RESET  = 10'd30;
    localparam logic [TIMER_W-1:0] SPIKE_RESET   = 10'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE  = 8'd1;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_FIRED    = 2'd2
    } phase_t;

    // per-word control shared by all lanes
    typedef struct packed {
        logic               accept;
        logic               startup;
        logic [TIMER_W-1:0] elapsed_ms;
    } poll_t;

    // thresholds from the configuration registers
    typedef struct packed {
        logic [TIMER_W-1:0] settle_ms;
        logic [TIMER_W-1:0] spike_ms;
    } thresh_t;

    // what one lane reports for the current word
    typedef struct packed {
        logic click;
        logic held;
    } lane_res_t;

    function automatic logic [TIMER_W-1:0] sat_add(
        input logic [TIMER_W-1:0] a,
        input logic [TIMER_W-1:0] b
    );
        logic [TIMER_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
        end
    endfunction

endpackage

>>> design/bdg_lane.sv
// one button lane: idle / debouncing / fired machine with saturating timers
module bdg_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  bdg_pkg::poll_t    poll,
    input  bdg_pkg::thresh_t  thresh,
    input  logic              low,
    output bdg_pkg::lane_res_t res
);
    import bdg_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] press_reg, press_next;
    logic [TIMER_W-1:0] rel_reg, rel_next;
    logic               rt_reg, rt_next;
    logic               held_reg, held_next;
    logic               fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            press_reg <= '0;
            rel_reg   <= '0;
            rt_reg    <= 1'b0;
            held_reg  <= 1'b0;
        end else if (poll.accept) begin
            phase_reg <= phase_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
            rt_reg    <= rt_next;
            held_reg  <= held_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        rt_next    = rt_reg;
        held_next  = held_reg;
        fire       = 1'b0;
        if (poll.startup) begin
            // boot guard: a button already down starts out fired
            if (low) begin
                phase_next = PH_FIRED;
                rt_next    = 1'b1;
                rel_next   = '0;
            end
        end else begin
            if (phase_reg == PH_DEBOUNCE) begin
                press_next = sat_add(press_reg, poll.elapsed_ms);
            end
            if (rt_reg) begin
                rel_next = sat_add(rel_reg, poll.elapsed_ms);
            end
            unique case (phase_reg)
                PH_DEBOUNCE: begin
                    if (!low) begin
                        if (!rt_reg) begin
                            rt_next  = 1'b1;
                            rel_next = '0;
                        end else if (rel_next >= thresh.spike_ms) begin
                            phase_next = PH_IDLE;
                            rt_next    = 1'b0;
                        end
                    end else begin
                        rt_next = 1'b0;
                        if (press_next >= thresh.settle_ms) begin
                            held_next  = 1'b1;
                            phase_next = PH_FIRED;
                            fire       = 1'b1;
                        end
                    end
                end
                PH_FIRED: begin
                    if (low) begin
                        rt_next = 1'b0;
                    end else if (!rt_reg) begin
                        rt_next  = 1'b1;
                        rel_next = '0;
                    end else if (rel_next >= thresh.settle_ms) begin
                        phase_next = PH_IDLE;
                        rt_next    = 1'b0;
                        held_next  = 1'b0;
                    end
                end
                default: begin
                    // idle, and the unused code behaves the same
                    if (low) begin
                        phase_next = PH_DEBOUNCE;
                        press_next = '0;
                        rt_next    = 1'b0;
                    end
                end
            endcase
        end
    end

    assign res.click = poll.accept & fire;
    assign res.held  = held_next;

    // held is only ever set while the lane sits in fired
    a_held_only_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> (phase_reg == PH_FIRED))
        else $error("lane held outside fired phase");

    // an idle lane never times a high spell
    a_idle_no_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !rt_reg)
        else $error("idle lane has release timing set");

    // a click leaves the lane fired and held
    a_click_then_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res.click |=> (held_reg && phase_reg == PH_FIRED))
        else $error("click did not leave lane fired and held");

    // clicks only come from a debouncing lane on a normal poll
    a_click_source: assert property (@(posedge aclk) disable iff (!aresetn)
        res.click |-> (!poll.startup && phase_reg == PH_DEBOUNCE))
        else $error("click from wrong phase or startup word");

endmodule

>>> design/bdg_merge.sv
// merge of lane results into the click / held masks and the output register
module bdg_merge #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_accept,
    input  bdg_pkg::lane_res_t [NUM_BUTTONS-1:0]   lane_res,
    output logic                                   in_ready,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [bdg_pkg::M_TDATA_W-1:0]          m_tdata
);
    import bdg_pkg::*;

    logic [MASK_W-1:0] click_next, held_next;
    logic [MASK_W-1:0] click_reg, held_reg;
    logic              valid_reg;

    // lanes past the mask width are dropped, missing lanes read as zero
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_lane
            assign click_next[j] = lane_res[j].click;
            assign held_next[j]  = lane_res[j].held;
        end else begin : g_none
            assign click_next[j] = 1'b0;
            assign held_next[j]  = 1'b0;
        end
    end

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_accept) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            click_reg <= click_next;
            held_reg  <= held_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*MASK_W){1'b0}}, held_reg, click_reg};

endmodule

>>> design/button_debounce_glitch_tolerant_core.sv
// top level of the glitch-tolerant button debouncer
// Each input word is one poll of up to six active-low buttons plus the
// milliseconds since the previous poll; a startup flag in tuser marks the
// first poll, on which buttons already down are taken as fired without a
// click. Every button has its own lane (idle, debouncing, fired) and all
// lanes update together, so the core takes one word per clock and returns
// exactly one word per poll, in the cycle after acceptance, from an output
// register; it keeps taking words while that register drains, stalling only
// when a result is waiting and m_tready is low. Thresholds come from two
// registers on the cfg port (index 0 settle time for press and re-arm,
// reset 30; index 1 spike time forgiven while debouncing, reset 8), written
// only while the core is idle: the user must keep to this, the core does not
// enforce it. There are no memories and no clearing pass after reset.
module button_debounce_glitch_tolerant_core #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // poll words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdg_pkg::S_TDATA_W-1:0]     s_tdata,  // levels_low[5:0], elapsed_ms[15:6]
    input  logic                              s_tuser,  // startup
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bdg_pkg::M_TDATA_W-1:0]     m_tdata,  // click_mask[5:0], held_mask[11:6], zero
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdg_pkg::TIMER_W-1:0]       cfg_data
);
    import bdg_pkg::*;

    logic [TIMER_W-1:0]               settle_ms_reg;
    logic [TIMER_W-1:0]               spike_ms_reg;
    logic [LEVELS_W-1:0]              levels_low;
    poll_t                            poll;
    thresh_t                          thresh;
    lane_res_t [NUM_BUTTONS-1:0]      lane_res;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ms_reg <= SETTLE_RESET;
            spike_ms_reg  <= SPIKE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SETTLE: settle_ms_reg <= cfg_data;
                CFG_SPIKE:  spike_ms_reg  <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign thresh.settle_ms = settle_ms_reg;
    assign thresh.spike_ms  = spike_ms_reg;

    // unpack the poll word
    assign levels_low      = s_tdata[LEVELS_W-1:0];
    assign poll.accept     = s_tvalid && s_tready;
    assign poll.startup    = s_tuser;
    assign poll.elapsed_ms = s_tdata[LEVELS_W +: TIMER_W];

    // one lane per button; lanes past the level field always read high
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic low;
        if (i < LEVELS_W) begin : g_in
            assign low = levels_low[i];
        end else begin : g_high
            assign low = 1'b0;
        end

        bdg_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .poll    (poll),
            .thresh  (thresh),
            .low     (low),
            .res     (lane_res[i])
        );
    end

    // combine lane results into the result word and hold it for the sink
    bdg_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (poll.accept),
        .lane_res  (lane_res),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/button_debounce_glitch_tolerant_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the glitch-tolerant button debouncer core
module button_debounce_glitch_tolerant_core_tb;
    import bdg_pkg::*;

    localparam int LANES            = 6;
    localparam int NUM_PHASES       = 8;
    localparam int POLLS_PER_PHASE  = 175;   // 8 phases, about 1400 random polls
    localparam int NUM_DIRECTED     = 23;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int END_WAIT_LIMIT   = 5000;

    // one result word as the lanes report it
    typedef struct packed {
        logic [MASK_W-1:0] click;
        logic [MASK_W-1:0] held;
    } poll_result_t;

    // directed row; click/held only meaningful when typed is set
    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic [TIMER_W-1:0]  elapsed;
        logic                startup;
        logic                typed;
        logic [MASK_W-1:0]   click;
        logic [MASK_W-1:0]   held;
    } poll_row_t;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

    // clock and reset
    logic aclk;
    logic aresetn = 1'b0;

    // poll words into the core
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // levels_low[5:0], elapsed_ms[15:6]
    logic                 s_tuser  = 1'b0;  // startup

    // result words out of the core
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // click_mask[5:0], held_mask[11:6], zero

    // threshold register writes
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIMER_W-1:0]   cfg_data  = '0;

    // predicted lane state, mirrors what the core should hold
    phase_t             lane_phase [LANES];
    logic [TIMER_W-1:0] press_ms   [LANES];
    logic [TIMER_W-1:0] release_ms [LANES];
    logic               release_on [LANES];
    logic               held_on    [LANES];
    logic [TIMER_W-1:0] debounce_cfg;
    logic [TIMER_W-1:0] glitch_cfg;

    // results still owed by the core, oldest first
    poll_result_t pending_polls [$];

    // sender burst shaping and receiver control, shared between processes
    int       burst_left = 0;
    logic     hold_req   = 1'b0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hFFFF;

    // run statistics
    int mismatches    = 0;
    int polls_sent    = 0;
    int results_seen  = 0;
    int clicks_seen   = 0;
    int startup_polls = 0;
    int cfg_writes    = 0;

    button_debounce_glitch_tolerant_core #(
        .NUM_BUTTONS (LANES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // elapsed counters stick at the top of their range
    function automatic logic [TIMER_W-1:0] add_clamp(
        input logic [TIMER_W-1:0] a,
        input logic [TIMER_W-1:0] b
    );
        logic [TIMER_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return (total > {1'b0, TIMER_MAX}) ? TIMER_MAX : total[TIMER_W-1:0];
    endfunction

    // advance every lane by one poll and return the click and held masks
    function automatic poll_result_t debounce_poll(
        input logic [LEVELS_W-1:0] levels,
        input logic [TIMER_W-1:0]  elapsed,
        input logic                startup
    );
        poll_result_t res;
        logic         low;
        res = '0;
        for (int i = 0; i < LANES; i++) begin
            low = levels[i];
            if (startup) begin
                // boot guard: buttons already down count as fired, no click
                if (low) begin
                    lane_phase[i] = PH_FIRED;
                    release_on[i] = 1'b1;
                    release_ms[i] = '0;
                end
            end else begin
                if (lane_phase[i] == PH_DEBOUNCE)
                    press_ms[i] = add_clamp(press_ms[i], elapsed);
                if (release_on[i])
                    release_ms[i] = add_clamp(release_ms[i], elapsed);
                case (lane_phase[i])
                    PH_DEBOUNCE: begin
                        if (!low) begin
                            // high glitch: time it, abort once it reaches the spike time
                            if (!release_on[i]) begin
                                release_on[i] = 1'b1;
                                release_ms[i] = '0;
                            end else if (release_ms[i] >= glitch_cfg) begin
                                lane_phase[i] = PH_IDLE;
                                release_on[i] = 1'b0;
                            end
                        end else begin
                            release_on[i] = 1'b0;
                            if (press_ms[i] >= debounce_cfg) begin
                                held_on[i]    = 1'b1;
                                lane_phase[i] = PH_FIRED;
                                res.click[i]  = 1'b1;
                            end
                        end
                    end
                    PH_FIRED: begin
                        if (low) begin
                            release_on[i] = 1'b0;
                        end else if (!release_on[i]) begin
                            release_on[i] = 1'b1;
                            release_ms[i] = '0;
                        end else if (release_ms[i] >= debounce_cfg) begin
                            // stable high long enough: re-arm
                            lane_phase[i] = PH_IDLE;
                            release_on[i] = 1'b0;
                            held_on[i]    = 1'b0;
                        end
                    end
                    default: begin
                        if (low) begin
                            lane_phase[i] = PH_DEBOUNCE;
                            press_ms[i]   = '0;
                            release_on[i] = 1'b0;
                        end
                    end
                endcase
            end
            res.held[i] = held_on[i];
        end
        return res;
    endfunction

    // offer one poll word, following the burst/gap pattern, and book its result
    task automatic send_poll(
        input logic [LEVELS_W-1:0] levels,
        input logic [TIMER_W-1:0]  elapsed,
        input logic                startup,
        input logic                typed,
        input poll_result_t        typed_res
    );
        int           gap;
        poll_result_t res;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {elapsed, levels};
        s_tuser  <= startup;
        burst_left--;
        do @(posedge aclk); while (!s_tready);
        res = debounce_poll(levels, elapsed, startup);
        pending_polls.push_back(typed ? typed_res : res);
        polls_sent++;
        if (startup)
            startup_polls++;
    endtask

    // stop offering and let every owed result come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_polls.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // one register write; the predictor takes it on acceptance
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [TIMER_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_SETTLE)
            debounce_cfg = value;
        else if (index == CFG_SPIKE)
            glitch_cfg = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: ready pattern per phase, plus a long hold on request
    initial begin : receiver
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long stall counted here while the sender keeps pushing
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_PATTERN: begin
                        m_tready   <= rx_pattern[15];
                        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
                    end
                    default:    m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge aclk) begin
        poll_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            clicks_seen += $countones(m_tdata[MASK_W-1:0]);
            if (pending_polls.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                mismatches++;
            end else begin
                exp_res = pending_polls.pop_front();
                if (m_tdata[MASK_W-1:0] !== exp_res.click) begin
                    $error("click_mask: expected %02h, actual %02h",
                           exp_res.click, m_tdata[MASK_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[2*MASK_W-1:MASK_W] !== exp_res.held) begin
                    $error("held_mask: expected %02h, actual %02h",
                           exp_res.held, m_tdata[2*MASK_W-1:MASK_W]);
                    mismatches++;
                end
                if (m_tdata[M_TDATA_W-1:2*MASK_W] !== '0) begin
                    $error("pad: expected 0, actual %h", m_tdata[M_TDATA_W-1:2*MASK_W]);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        poll_row_t           dir_rows [NUM_DIRECTED];
        logic [TIMER_W-1:0]  phase_debounce [NUM_PHASES];
        logic [TIMER_W-1:0]  phase_glitch   [NUM_PHASES];
        logic [LEVELS_W-1:0] lane_target;
        logic [LEVELS_W-1:0] levels;
        logic [TIMER_W-1:0]  elapsed;
        logic                startup;
        int                  pick;
        int                  span;
        int                  top;
        int                  waited;

        // directed rows under the reset thresholds (debounce 30, glitch 8)
        dir_rows = '{
            // startup with everything down: fired, no click, nothing held yet
            '{6'h3F, 10'd1023, 1'b1, 1'b1, 6'h00, 6'h00},
            // long high re-arms every lane
            '{6'h00, 10'd1023, 1'b0, 1'b1, 6'h00, 6'h00},
            // all down: enter debouncing
            '{6'h3F, 10'd0,    1'b0, 1'b1, 6'h00, 6'h00},
            // saturated press time: every lane clicks
            '{6'h3F, 10'd1023, 1'b0, 1'b1, 6'h3F, 6'h3F},
            '{6'h3F, 10'd1023, 1'b0, 1'b1, 6'h00, 6'h3F},
            // release spell starts, still held
            '{6'h00, 10'd1,    1'b0, 1'b1, 6'h00, 6'h3F},
            '{6'h00, 10'd1022, 1'b0, 1'b1, 6'h00, 6'h00},
            // lane 0: glitch that lasts the spike time aborts the press
            '{6'h01, 10'd10,   1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h00, 10'd10,   1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h01, 10'd7,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h00, 10'd3,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h00, 10'd8,    1'b0, 1'b0, 6'h00, 6'h00},
            // lane 0: short glitch forgiven, press completes
            '{6'h01, 10'd0,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h01, 10'd0,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h00, 10'd7,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h01, 10'd23,   1'b0, 1'b0, 6'h00, 6'h00},
            // re-arm cut short by a low sample
            '{6'h00, 10'd29,   1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h00, 10'd29,   1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h01, 10'd5,    1'b0, 1'b0, 6'h00, 6'h00},
            // startup in mid-run keeps held flags, ignores elapsed
            '{6'h12, 10'd500,  1'b1, 1'b0, 6'h00, 6'h00},
            '{6'h20, 10'd3,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h3F, 10'd0,    1'b0, 1'b0, 6'h00, 6'h00},
            '{6'h2D, 10'd30,   1'b0, 1'b0, 6'h00, 6'h00}
        };

        // threshold settings per random phase, extremes first
        phase_debounce = '{10'd0, 10'd1023, 10'd0,    10'd1023, 10'd30, 10'd12, 10'd0, 10'd0};
        phase_glitch   = '{10'd0, 10'd1023, 10'd1023, 10'd0,    10'd8,  10'd4,  10'd0, 10'd0};
        phase_debounce[6] = TIMER_W'($urandom_range(1, 80));
        phase_glitch[6]   = TIMER_W'($urandom_range(1, 40));
        phase_debounce[7] = TIMER_W'($urandom_range(0, 1023));
        phase_glitch[7]   = TIMER_W'($urandom_range(0, 1023));

        // predictor state after reset
        for (int i = 0; i < LANES; i++) begin
            lane_phase[i] = PH_IDLE;
            press_ms[i]   = '0;
            release_ms[i] = '0;
            release_on[i] = 1'b0;
            held_on[i]    = 1'b0;
        end
        debounce_cfg = SETTLE_RESET;
        glitch_cfg   = SPIKE_RESET;
        lane_target  = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, receiver always ready
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_poll(dir_rows[r].levels, dir_rows[r].elapsed, dir_rows[r].startup,
                      dir_rows[r].typed, {dir_rows[r].click, dir_rows[r].held});
        drain_results();

        // random phases, each under a fresh threshold setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(CFG_SETTLE, phase_debounce[p]);
                cfg_write(CFG_SPIKE, phase_glitch[p]);
            end else begin
                cfg_write(CFG_SPIKE, phase_glitch[p]);
                cfg_write(CFG_SETTLE, phase_debounce[p]);
            end
            // an index outside the register list must change nothing
            cfg_write(CFG_SPIKE + 8'd1 + CFG_IDX_W'($urandom_range(0, 253)),
                      TIMER_W'($urandom_range(0, 1023)));

            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            rx_pattern = (p == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));

            for (int n = 0; n < POLLS_PER_PHASE; n++) begin
                // once: hold the receiver off while words keep coming
                if (p == 2 && n == 40) begin
                    hold_req   = 1'b1;
                    burst_left = 1000;
                end
                // once: pause the sender until everything is back
                if (p == 4 && n == 90)
                    drain_results();

                // mostly plausible press/release sequences with glitches, some noise
                if ($urandom_range(0, 19) == 0) begin
                    levels = LEVELS_W'($urandom_range(0, 63));
                end else begin
                    for (int i = 0; i < LANES; i++)
                        if ($urandom_range(0, 9) == 0)
                            lane_target[i] = ~lane_target[i];
                    levels = lane_target;
                    if ($urandom_range(0, 7) == 0)
                        levels[$urandom_range(0, LANES-1)] ^= 1'b1;
                end
                startup = ($urandom_range(0, 149) == 0);

                // elapsed scaled to the thresholds so spells end both ways
                pick = $urandom_range(0, 99);
                span = ((debounce_cfg > glitch_cfg) ? debounce_cfg : glitch_cfg) / 4 + 2;
                top  = debounce_cfg + glitch_cfg + 2;
                if (top > 1023)
                    top = 1023;
                if (pick < 3)
                    elapsed = TIMER_MAX;
                else if (pick < 12)
                    elapsed = '0;
                else if (pick < 60)
                    elapsed = TIMER_W'($urandom_range(0, span));
                else if (pick < 88)
                    elapsed = TIMER_W'($urandom_range(0, top));
                else
                    elapsed = TIMER_W'($urandom_range(0, 1023));

                send_poll(levels, elapsed, startup, 1'b0, '0);
            end
            drain_results();
        end

        // final wait, bounded, then the verdict
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (waited = 0; waited < END_WAIT_LIMIT && pending_polls.size() != 0; waited++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_polls.size() != 0) begin
            $error("%0d results never arrived", pending_polls.size());
            mismatches++;
        end

        $display("covered %0d polls (%0d startup) over %0d threshold settings, %0d config writes",
                 polls_sent, startup_polls, NUM_PHASES + 1, cfg_writes);
        $display("checked %0d result words carrying %0d clicks, %0d field mismatches",
                 results_seen, clicks_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
